// File: src/kmsd_pkg.sv
package kmsd_pkg;

    // Matrix geometry.
    localparam int NUM_COLS = 3;
    localparam int NUM_ROWS = 5;

    localparam int ROW_W   = 5;
    localparam int CODE_W  = 4;
    localparam int DRIVE_W = 3;
    localparam int EVENT_W = 2;
    localparam int COL_W   = (NUM_COLS > 1) ? $clog2(NUM_COLS) : 1;

    // Rows that take part in a scan.
    localparam int SCAN_ROWS = (NUM_ROWS < ROW_W) ? NUM_ROWS : ROW_W;

    // Column drive value with no column pulled low.
    localparam logic [DRIVE_W-1:0] DRIVE_IDLE = DRIVE_W'(((1 << NUM_COLS) - 1) & 7);

    localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;
    localparam logic [7:0]  GAP_MAX     = 8'hFF;
    localparam logic [3:0]  EMPTY_MAX   = 4'hF;

    // Configuration register indexes.
    localparam logic [1:0] CFG_TIMEOUT  = 2'd0;
    localparam logic [1:0] CFG_DEBOUNCE = 2'd1;
    localparam logic [1:0] CFG_POLL     = 2'd2;
    localparam logic [1:0] CFG_RELEASE  = 2'd3;

    // Event codes carried on event_res.
    localparam logic [EVENT_W-1:0] EV_NONE    = 2'd0;
    localparam logic [EVENT_W-1:0] EV_PRESS   = 2'd1;
    localparam logic [EVENT_W-1:0] EV_RELEASE = 2'd2;
    localparam logic [EVENT_W-1:0] EV_TIMEOUT = 2'd3;

    typedef enum logic [2:0] {
        PH_SCAN1 = 3'd0,
        PH_DGAP  = 3'd1,
        PH_SCAN2 = 3'd2,
        PH_PGAP  = 3'd3,
        PH_RSCAN = 3'd4,
        PH_RGAP  = 3'd5
    } phase_t;

    typedef struct packed {
        logic [15:0] wait_limit_ms;
        logic [7:0]  debounce_gap_ms;
        logic [7:0]  poll_gap_ms;
        logic [3:0]  release_samples;
    } cfg_t;

    typedef struct packed {
        logic [DRIVE_W-1:0] col_drive;
        logic [EVENT_W-1:0] event_res;
        logic [CODE_W-1:0]  key_code;
    } result_t;

endpackage

// File: src/kmsd_fsm.sv
module kmsd_fsm
    import kmsd_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             step,
    input  logic [ROW_W-1:0] row_levels,
    input  logic             ms_pulse,
    input  cfg_t             cfg,
    output result_t          res
);

    phase_t            phase_reg, phase_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [CODE_W-1:0] first_code_reg, first_code_next;
    logic [CODE_W-1:0] held_code_reg, held_code_next;
    logic [7:0]        gap_count_reg, gap_count_next;
    logic [15:0]       elapsed_reg, elapsed_next;
    logic [3:0]        empty_count_reg, empty_count_next;

    always_comb
    begin
        logic              hit;
        logic [CODE_W-1:0] hit_code;
        logic [7:0]        gap_inc;
        logic              poll_done;
        logic              rel_done;
        logic [16:0]       elapsed_sum;
        logic [15:0]       elapsed_sat;
        logic [3:0]        need;
        logic [COL_W:0]    col_plus;

        phase_next       = phase_reg;
        col_next         = col_reg;
        first_code_next  = first_code_reg;
        held_code_next   = held_code_reg;
        gap_count_next   = gap_count_reg;
        elapsed_next     = elapsed_reg;
        empty_count_next = empty_count_reg;
        res.event_res    = EV_NONE;
        res.key_code     = '0;
        poll_done        = 1'b0;
        rel_done         = 1'b0;

        // Priority search: the lowest low row wins.
        hit      = 1'b0;
        hit_code = '0;
        for (int r = SCAN_ROWS - 1; r >= 0; r--) begin
            if (!row_levels[r]) begin
                hit      = 1'b1;
                hit_code = CODE_W'(r * NUM_COLS) + CODE_W'(col_reg);
            end
        end

        gap_inc  = gap_count_reg + 8'((ms_pulse && gap_count_reg < GAP_MAX) ? 1 : 0);
        col_plus = {1'b0, col_reg} + (COL_W+1)'(1);

        case (phase_reg)
            PH_SCAN1, PH_SCAN2, PH_RSCAN:
            begin
                if (!hit && col_plus < (COL_W+1)'(NUM_COLS)) begin
                    col_next = col_plus[COL_W-1:0];
                end else if (phase_reg == PH_SCAN1) begin
                    if (!hit) begin
                        gap_count_next = '0;
                        if (cfg.poll_gap_ms == '0) poll_done = 1'b1;
                        else phase_next = PH_PGAP;
                    end else begin
                        first_code_next = hit_code;
                        gap_count_next  = '0;
                        if (cfg.debounce_gap_ms == '0) begin
                            phase_next = PH_SCAN2;
                            col_next   = '0;
                        end else begin
                            phase_next = PH_DGAP;
                        end
                    end
                end else if (phase_reg == PH_SCAN2) begin
                    if (hit && hit_code == first_code_reg) begin
                        held_code_next   = first_code_reg;
                        res.event_res    = EV_PRESS;
                        res.key_code     = first_code_reg;
                        empty_count_next = '0;
                        phase_next       = PH_RSCAN;
                        col_next         = '0;
                    end else begin
                        gap_count_next = '0;
                        if (cfg.poll_gap_ms == '0) poll_done = 1'b1;
                        else phase_next = PH_PGAP;
                    end
                end else begin
                    if (!hit) begin
                        if (empty_count_reg < EMPTY_MAX) empty_count_next = empty_count_reg + 4'd1;
                    end else begin
                        empty_count_next = '0;
                    end
                    gap_count_next = '0;
                    if (cfg.poll_gap_ms == '0) rel_done = 1'b1;
                    else phase_next = PH_RGAP;
                end
            end
            PH_DGAP:
            begin
                gap_count_next = gap_inc;
                if (gap_inc >= cfg.debounce_gap_ms) begin
                    phase_next = PH_SCAN2;
                    col_next   = '0;
                end
            end
            PH_PGAP:
            begin
                gap_count_next = gap_inc;
                poll_done      = (gap_inc >= cfg.poll_gap_ms);
            end
            PH_RGAP:
            begin
                gap_count_next = gap_inc;
                rel_done       = (gap_inc >= cfg.poll_gap_ms);
            end
            default:
            begin
                elapsed_next = '0;
                phase_next   = PH_SCAN1;
                col_next     = '0;
            end
        endcase

        // A failed poll adds its gap to the elapsed time and may time out.
        elapsed_sum = {1'b0, elapsed_reg} + 17'(cfg.poll_gap_ms);
        elapsed_sat = elapsed_sum[16] ? ELAPSED_MAX : elapsed_sum[15:0];
        if (poll_done) begin
            phase_next = PH_SCAN1;
            col_next   = '0;
            if (cfg.wait_limit_ms != '0 && elapsed_sat >= cfg.wait_limit_ms) begin
                res.event_res = EV_TIMEOUT;
                res.key_code  = '0;
                elapsed_next  = '0;
            end else begin
                elapsed_next = elapsed_sat;
            end
        end

        need = (cfg.release_samples == '0) ? 4'd1 : cfg.release_samples;
        if (rel_done) begin
            col_next = '0;
            if (empty_count_next >= need) begin
                res.event_res = EV_RELEASE;
                res.key_code  = held_code_reg;
                elapsed_next  = '0;
                phase_next    = PH_SCAN1;
            end else begin
                phase_next = PH_RSCAN;
            end
        end

        if (phase_next == PH_SCAN1 || phase_next == PH_SCAN2 || phase_next == PH_RSCAN)
            res.col_drive = DRIVE_IDLE & ~(DRIVE_W'(1) << col_next);
        else
            res.col_drive = DRIVE_IDLE;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg       <= PH_SCAN1;
            col_reg         <= '0;
            first_code_reg  <= '0;
            held_code_reg   <= '0;
            gap_count_reg   <= '0;
            elapsed_reg     <= '0;
            empty_count_reg <= '0;
        end else if (step) begin
            phase_reg       <= phase_next;
            col_reg         <= col_next;
            first_code_reg  <= first_code_next;
            held_code_reg   <= held_code_next;
            gap_count_reg   <= gap_count_next;
            elapsed_reg     <= elapsed_next;
            empty_count_reg <= empty_count_next;
        end
    end

    // The elapsed count moves only when an item is processed.
    a_elapsed_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(elapsed_reg))
        else $error("elapsed count changed without a processed item");

    // A press always leads into the release scan.
    a_press_to_rscan: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.event_res == EV_PRESS |=> phase_reg == PH_RSCAN && col_reg == '0)
        else $error("press did not start the release scan");

    // A timeout restarts the press wait with a cleared elapsed count.
    a_timeout_restart: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.event_res == EV_TIMEOUT |=> phase_reg == PH_SCAN1 && elapsed_reg == '0)
        else $error("timeout did not restart the press wait");

    // A release reports the key that was held.
    a_release_code: assert property (@(posedge clk) disable iff (!rst_n)
        step && res.event_res == EV_RELEASE |-> res.key_code == held_code_reg)
        else $error("release reported a key other than the held one");

endmodule

// File: src/keypad_matrix_scan_debounce_top.sv
// Channel   | Direction | Handshake                | Payload
// ----------+-----------+--------------------------+----------------------------------------
// in        | input     | in_valid / in_ready      | row_levels[4:0], ms_pulse
// out       | output    | out_valid / out_ready    | col_drive[2:0], event_res[1:0], key_code[3:0]
// cfg       | input     | cfg_valid / cfg_ready    | cfg_index[1:0], cfg_data[15:0]
//
// One request is taken per clock cycle while the output is not stalled; each input
// request gives exactly one result. A request is held in the input register, and
// its result is loaded into the output register when it advances, raising out_valid.
// The scan state machine updates once per request through short combinational logic.
// Reset clears the scan state, the handshake valids and restores register defaults.
// A stalled output holds its result and the input register, which then holds in_ready low.
module keypad_matrix_scan_debounce_top
    import kmsd_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,

    input  logic               in_valid,
    output logic               in_ready,
    input  logic [ROW_W-1:0]   row_levels,
    input  logic               ms_pulse,

    output logic               out_valid,
    input  logic               out_ready,
    output logic [DRIVE_W-1:0] col_drive,
    output logic [EVENT_W-1:0] event_res,
    output logic [CODE_W-1:0]  key_code,

    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);

    // Configuration registers. Writes must arrive only while the block is idle; it does not check.
    cfg_t cfg_reg;

    // Input register stage.
    logic             in_valid_reg;
    logic [ROW_W-1:0] rows_reg;
    logic             pulse_reg;

    // Output register stage.
    logic    out_valid_reg;
    result_t out_data_reg;
    result_t step_res;

    logic advance;

    // The stored request moves on when the output register is free or is being drained.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.wait_limit_ms   <= 16'd0;
            cfg_reg.debounce_gap_ms <= 8'd8;
            cfg_reg.poll_gap_ms     <= 8'd5;
            cfg_reg.release_samples <= 4'd3;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_TIMEOUT:  cfg_reg.wait_limit_ms   <= cfg_data;
                CFG_DEBOUNCE: cfg_reg.debounce_gap_ms <= cfg_data[7:0];
                CFG_POLL:     cfg_reg.poll_gap_ms     <= cfg_data[7:0];
                CFG_RELEASE:  cfg_reg.release_samples <= cfg_data[3:0];
                default:      cfg_reg                 <= cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            rows_reg  <= row_levels;
            pulse_reg <= ms_pulse;
        end
    end

    // The scan state machine advances once for each request leaving the input register.
    kmsd_fsm u_fsm (
        .clk        (clk),
        .rst_n      (rst_n),
        .step       (advance),
        .row_levels (rows_reg),
        .ms_pulse   (pulse_reg),
        .cfg        (cfg_reg),
        .res        (step_res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance) begin
            out_data_reg <= step_res;
        end
    end

    assign out_valid = out_valid_reg;
    assign col_drive = out_data_reg.col_drive;
    assign event_res = out_data_reg.event_res;
    assign key_code  = out_data_reg.key_code;

endmodule

// File: bench/keypad_matrix_scan_debounce_top_tb.sv
module keypad_matrix_scan_debounce_top_tb
    import kmsd_pkg::*;
();

    // Generous cycle limit. The slowest correct run is roughly 1350 requests, each
    // waiting out the longest sender gap and the longest receiver stall.
    localparam int CYCLE_LIMIT = 500000;

    // Opening directed requests, packed as {ms_pulse, row_levels}. They are run with
    // timeout 2, debounce gap 0, poll gap 1 and a release count of 0. In order, they
    // exercise an empty pass with a millisecond pulse during the scan, a failed poll,
    // a timeout, a press with no debounce wait, a release with the zero count acting
    // as one, a press on the last row of the middle column, and a release pass that
    // sees a key still down.
    localparam logic [5:0] OPENING [23] = '{
        6'h3F, 6'h1F, 6'h1F, 6'h00, 6'h3F, 6'h1F, 6'h1F, 6'h1F,
        6'h3F, 6'h00, 6'h00, 6'h3F, 6'h1F, 6'h1F, 6'h1F, 6'h20,
        6'h1F, 6'h0F, 6'h3F, 6'h2F, 6'h1F, 6'h1E, 6'h3F
    };

    // The checker keeps its own copy of the scan state machine and the registers.
    // Every accepted request is stepped through it right away, and the expected
    // output goes into a queue that the receiver drains in order.
    class keypad_checker;
        cfg_t               regs;
        phase_t             phase;
        logic [COL_W-1:0]   column;
        logic [CODE_W-1:0]  first_code;
        logic [CODE_W-1:0]  held_code;
        logic [7:0]         gap_count;
        logic [15:0]        elapsed_ms;
        logic [3:0]         empty_count;
        logic [EVENT_W-1:0] ev;
        logic [CODE_W-1:0]  ev_code;
        result_t            expected_outputs[$];
        int                 errors;
        int                 checked;

        function new();
            regs.wait_limit_ms   = 16'd0;
            regs.debounce_gap_ms = 8'd8;
            regs.poll_gap_ms     = 8'd5;
            regs.release_samples = 4'd3;
            phase       = PH_SCAN1;
            column      = '0;
            first_code  = '0;
            held_code   = '0;
            gap_count   = '0;
            elapsed_ms  = '0;
            empty_count = '0;
            errors      = 0;
            checked     = 0;
        endfunction

        function void set_register(logic [1:0] index, logic [15:0] data);
            case (index)
                CFG_TIMEOUT:  regs.wait_limit_ms   = data;
                CFG_DEBOUNCE: regs.debounce_gap_ms = data[7:0];
                CFG_POLL:     regs.poll_gap_ms     = data[7:0];
                CFG_RELEASE:  regs.release_samples = data[3:0];
                default: ;
            endcase
        endfunction

        function bit scanning();
            return phase == PH_SCAN1 || phase == PH_SCAN2 || phase == PH_RSCAN;
        endfunction

        function void start_scan(phase_t next);
            phase  = next;
            column = '0;
        endfunction

        function void restart_press_wait();
            elapsed_ms = '0;
            start_scan(PH_SCAN1);
        endfunction

        // Only millisecond pulses move a wait along; a length of zero ends it at once.
        function bit gap_elapsed(logic pulse, logic [7:0] len);
            if (pulse && gap_count != GAP_MAX)
                gap_count++;
            return gap_count >= len;
        endfunction

        function void finish_poll();
            int sum;
            sum = int'(elapsed_ms) + int'(regs.poll_gap_ms);
            elapsed_ms = (sum > 65535) ? ELAPSED_MAX : 16'(sum);
            if (regs.wait_limit_ms != 0 && elapsed_ms >= regs.wait_limit_ms)
            begin
                ev      = EV_TIMEOUT;
                ev_code = '0;
                restart_press_wait();
            end
            else
                start_scan(PH_SCAN1);
        endfunction

        function void finish_release_wait();
            int need;
            need = (regs.release_samples == 0) ? 1 : int'(regs.release_samples);
            if (int'(empty_count) >= need)
            begin
                ev      = EV_RELEASE;
                ev_code = held_code;
                restart_press_wait();
            end
            else
                start_scan(PH_RSCAN);
        endfunction

        function void enter_poll_gap();
            gap_count = '0;
            if (regs.poll_gap_ms == 0)
                finish_poll();
            else
                phase = PH_PGAP;
        endfunction

        function void predict_scan_step(logic [ROW_W-1:0] rows, logic pulse);
            int      hit;
            int      r;
            result_t res;
            ev      = EV_NONE;
            ev_code = '0;
            case (phase)
                PH_SCAN1, PH_SCAN2, PH_RSCAN:
                begin
                    hit = -1;
                    for (r = SCAN_ROWS - 1; r >= 0; r--)
                        if (!rows[r])
                            hit = r * NUM_COLS + int'(column);
                    if (hit < 0 && int'(column) + 1 < NUM_COLS)
                        column++;
                    else if (phase == PH_SCAN1)
                    begin
                        if (hit < 0)
                            enter_poll_gap();
                        else
                        begin
                            first_code = CODE_W'(hit);
                            gap_count  = '0;
                            if (regs.debounce_gap_ms == 0)
                                start_scan(PH_SCAN2);
                            else
                                phase = PH_DGAP;
                        end
                    end
                    else if (phase == PH_SCAN2)
                    begin
                        if (hit >= 0 && CODE_W'(hit) == first_code)
                        begin
                            held_code   = first_code;
                            ev          = EV_PRESS;
                            ev_code     = held_code;
                            empty_count = '0;
                            start_scan(PH_RSCAN);
                        end
                        else
                            enter_poll_gap();
                    end
                    else
                    begin
                        if (hit >= 0)
                            empty_count = '0;
                        else if (empty_count != EMPTY_MAX)
                            empty_count++;
                        gap_count = '0;
                        if (regs.poll_gap_ms == 0)
                            finish_release_wait();
                        else
                            phase = PH_RGAP;
                    end
                end
                PH_DGAP:
                    if (gap_elapsed(pulse, regs.debounce_gap_ms))
                        start_scan(PH_SCAN2);
                PH_PGAP:
                    if (gap_elapsed(pulse, regs.poll_gap_ms))
                        finish_poll();
                PH_RGAP:
                    if (gap_elapsed(pulse, regs.poll_gap_ms))
                        finish_release_wait();
                default:
                    restart_press_wait();
            endcase
            res.col_drive = scanning() ? (DRIVE_IDLE & ~(DRIVE_W'(1) << column)) : DRIVE_IDLE;
            res.event_res = ev;
            res.key_code  = ev_code;
            expected_outputs.push_back(res);
        endfunction

        task report(string what);
            errors++;
            if (errors <= 100)
                $display("mismatch: %s", what);
        endtask

        task check_output(logic [DRIVE_W-1:0] drive, logic [EVENT_W-1:0] evr,
                          logic [CODE_W-1:0] code);
            result_t want;
            checked++;
            if (expected_outputs.size() == 0)
            begin
                report($sformatf("output %0d arrived with nothing expected", checked));
                return;
            end
            want = expected_outputs.pop_front();
            if (drive !== want.col_drive)
                report($sformatf("output %0d col_drive %0d, expected %0d",
                                 checked, drive, want.col_drive));
            if (evr !== want.event_res)
                report($sformatf("output %0d event_res %0d, expected %0d",
                                 checked, evr, want.event_res));
            if (code !== want.key_code)
                report($sformatf("output %0d key_code %0d, expected %0d",
                                 checked, code, want.key_code));
        endtask
    endclass

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_ready;
    logic [ROW_W-1:0]   row_levels;
    logic               ms_pulse;
    logic               out_valid;
    logic               out_ready;
    logic [DRIVE_W-1:0] col_drive;
    logic [EVENT_W-1:0] event_res;
    logic [CODE_W-1:0]  key_code;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [1:0]         cfg_index;
    logic [15:0]        cfg_data;

    keypad_checker board = new();

    // A simulated key on the matrix. While it is down, the row levels offered for
    // its column show its row low; it toggles after a random number of requests.
    bit key_down;
    int key_row;
    int key_col;
    int key_left;

    // When the sender is calm it offers requests back to back.
    bit sender_calm;

    keypad_matrix_scan_debounce_top dut (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Offers one request and holds it until the block takes it. The request is
    // stepped through the checker at the edge where it is accepted. Valid is not
    // lowered here, so that a following request can go out on the next cycle.
    task automatic send_request(logic [ROW_W-1:0] rows, logic pulse);
        in_valid   <= 1'b1;
        row_levels <= rows;
        ms_pulse   <= pulse;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        board.predict_scan_step(rows, pulse);
    endtask

    task automatic write_register(logic [1:0] index, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        board.set_register(index, data);
    endtask

    // Writes all four registers. The 8-bit and 4-bit registers get random upper data
    // bits, which the block must ignore.
    task automatic apply_config(logic [15:0] timeout, logic [7:0] debounce,
                                logic [7:0] poll, logic [3:0] samples);
        write_register(CFG_TIMEOUT, timeout);
        write_register(CFG_DEBOUNCE, {8'($urandom), debounce});
        write_register(CFG_POLL, {8'($urandom), poll});
        write_register(CFG_RELEASE, {12'($urandom), samples});
        cfg_valid <= 1'b0;
    endtask

    // Registers change only when the block is idle, so the sender waits here until
    // every expected output has come back.
    task automatic drain();
        while (board.expected_outputs.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Random requests that mostly follow the simulated key: the rows offered match
    // the column the block is driving, with a small share of random noise that
    // stands in for bounce and extra keys. Rows offered during waits are random,
    // since the block ignores them.
    task automatic run_random(int count, int pulse_pm, int noise_pm,
                              int short_max, int long_max);
        int               n;
        int               gap;
        int               pick;
        logic [ROW_W-1:0] rows;
        for (n = 0; n < count; n++)
        begin
            if ($urandom_range(63) == 0)
                sender_calm = !sender_calm;
            gap  = 0;
            pick = $urandom_range(99);
            if (!sender_calm && pick >= 65)
                gap = (pick < 92) ? $urandom_range(3, 1) : $urandom_range(30, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end

            if (!board.scanning() || $urandom_range(999) < noise_pm)
                rows = ROW_W'($urandom);
            else
            begin
                rows = '1;
                if (key_down && key_col == int'(board.column))
                    rows[key_row] = 1'b0;
            end
            send_request(rows, $urandom_range(999) < pulse_pm);

            key_left--;
            if (key_left <= 0)
            begin
                key_down = !key_down;
                key_row  = $urandom_range(NUM_ROWS - 1);
                key_col  = $urandom_range(NUM_COLS - 1);
                key_left = ($urandom_range(4) == 0) ? $urandom_range(long_max, short_max)
                                                    : $urandom_range(short_max, 2);
            end
        end
        in_valid <= 1'b0;
    endtask

    // Receiver. It checks each accepted output against the oldest expectation and
    // stalls at random: mostly short stalls, a few long ones, and calm stretches with
    // none. Once, after a few hundred outputs, it holds off long enough for the block
    // to fill up and stall the sender.
    initial
    begin : receiver
        int stall;
        bit calm;
        bit long_hold_done;
        stall          = 0;
        calm           = 1'b0;
        long_hold_done = 1'b0;
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_output(col_drive, event_res, key_code);
            if ($urandom_range(127) == 0)
                calm = !calm;
            if (!long_hold_done && board.checked >= 400)
            begin
                long_hold_done = 1'b1;
                stall          = 80;
            end
            else if (stall == 0 && !calm && $urandom_range(99) >= 70)
                stall = ($urandom_range(9) == 0) ? $urandom_range(30, 10)
                                                 : $urandom_range(3, 1);
            if (stall > 0)
            begin
                stall--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // The run is cut off if it takes far longer than any correct run could.
    initial
    begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("status: fail");
        $finish;
    end

    initial
    begin : stimulus
        int i;
        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        row_levels <= '1;
        ms_pulse   <= 1'b0;
        cfg_valid  <= 1'b0;
        cfg_index  <= CFG_TIMEOUT;
        cfg_data   <= '0;
        key_down    = 1'b0;
        key_row     = 0;
        key_col     = 0;
        key_left    = 10;
        sender_calm = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part with a short timeout, no debounce wait, a one millisecond
        // poll gap and a release count of zero.
        apply_config(16'd2, 8'd0, 8'd1, 4'd0);
        for (i = 0; i < 23; i++)
            send_request(OPENING[i][4:0], OPENING[i][5]);
        in_valid <= 1'b0;
        drain();

        // Reset values, with about half the settle periods ending a millisecond.
        apply_config(16'd0, 8'd8, 8'd5, 4'd3);
        run_random(250, 500, 60, 40, 200);
        drain();

        // A short timeout that fires often between presses.
        apply_config(16'd20, 8'd2, 8'd3, 4'd1);
        run_random(250, 500, 60, 30, 120);
        drain();

        // Zero gaps everywhere, the longest timeout and the largest release count.
        apply_config(16'hFFFF, 8'd0, 8'd0, 4'd15);
        run_random(250, 300, 60, 40, 150);
        drain();

        // The longest debounce and poll gaps, with nearly every period a millisecond.
        apply_config(16'd30, 8'd255, 8'd255, 4'd2);
        run_random(300, 950, 40, 80, 700);
        drain();

        // A random small setting.
        apply_config(16'($urandom_range(200)), 8'($urandom_range(12)),
                     8'($urandom_range(10)), 4'($urandom));
        run_random(250, 500, 60, 40, 200);

        drain();
        repeat (10) @(posedge clk);
        if (board.expected_outputs.size() != 0)
            board.report($sformatf("%0d expected outputs never arrived",
                                   board.expected_outputs.size()));
        if (board.errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
